// ===== sv/tbp_pkg.sv =====
`timescale 1ns / 1ps

package tbp_pkg;

    localparam int INDEX_BITS_DEF   = 11;
    localparam int HISTORY_BITS_DEF = 11;
    localparam int ADDR_W           = 32;
    localparam int COUNT_W          = 32;
    localparam int CTR_W            = 2;

    localparam logic [CTR_W-1:0] CTR_STRONG_NT    = 2'd0;
    localparam logic [CTR_W-1:0] CTR_WEAK_T       = 2'd2;
    localparam logic [CTR_W-1:0] CTR_STRONG_T     = 2'd3;
    localparam logic [CTR_W-1:0] CHO_STRONG_GSH   = 2'd0;
    localparam logic [CTR_W-1:0] CHO_WEAK_BIM     = 2'd2;
    localparam logic [CTR_W-1:0] CHO_STRONG_BIM   = 2'd3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } tbp_state_t;

    typedef struct packed {
        logic [CTR_W-1:0] bim_next;
        logic [CTR_W-1:0] gsh_next;
        logic [CTR_W-1:0] cho_next;
        logic             pred;
        logic             hit;
        logic             use_gshare;
    } tbp_upd_t;

endpackage

// ===== sv/tbp_ram.sv =====
`timescale 1ns / 1ps

module tbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/tbp_update.sv =====
`timescale 1ns / 1ps

module tbp_update import tbp_pkg::*; (
    input  logic [CTR_W-1:0] bim_ctr,
    input  logic [CTR_W-1:0] gsh_ctr,
    input  logic [CTR_W-1:0] cho_ctr,
    input  logic             taken,
    output tbp_upd_t         upd
);

    logic bim_pred;
    logic gsh_pred;
    logic bim_ok;
    logic gsh_ok;
    logic pick_gsh;

    function automatic logic [CTR_W-1:0] train(input logic [CTR_W-1:0] c, input logic t);
        logic [CTR_W-1:0] r;
        r = c;
        if (t) begin
            if (c != CTR_STRONG_T) r = c + CTR_W'(1);
        end else begin
            if (c != CTR_STRONG_NT) r = c - CTR_W'(1);
        end
        return r;
    endfunction

    always_comb begin
        bim_pred = (bim_ctr >= CTR_WEAK_T);
        gsh_pred = (gsh_ctr >= CTR_WEAK_T);
        pick_gsh = (cho_ctr < CHO_WEAK_BIM);
        bim_ok   = (bim_pred == taken);
        gsh_ok   = (gsh_pred == taken);

        upd.bim_next   = train(bim_ctr, taken);
        upd.gsh_next   = train(gsh_ctr, taken);
        upd.cho_next   = cho_ctr;
        if (bim_ok && !gsh_ok && cho_ctr != CHO_STRONG_BIM) begin
            upd.cho_next = cho_ctr + CTR_W'(1);
        end else if (!bim_ok && gsh_ok && cho_ctr != CHO_STRONG_GSH) begin
            upd.cho_next = cho_ctr - CTR_W'(1);
        end
        upd.pred       = pick_gsh ? gsh_pred : bim_pred;
        upd.hit        = (upd.pred == taken);
        upd.use_gshare = pick_gsh;
    end

endmodule

// ===== sv/tournament_branch_predictor.sv =====
// Tournament branch predictor (bimodal + gshare + chooser) trained by resolved
// branches. Each request carries a branch address and its outcome and yields one
// result: the chosen prediction, whether it was right, which component was used
// and the saturating count of correct predictions so far. After reset the block
// writes the initial counter values into all 2^INDEX_BITS table entries (2048 by
// default) and holds s_ready low meanwhile. Then a request goes through the
// registered table read and then training and write-back, and the next request
// is accepted only once that write-back is done. A finished result waits in the
// output register while the next request is read; write-back stalls only if that
// register is still full when the following result is ready.
`timescale 1ns / 1ps

module tournament_branch_predictor import tbp_pkg::*; #(
    parameter int INDEX_BITS   = INDEX_BITS_DEF,
    parameter int HISTORY_BITS = HISTORY_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [ADDR_W-1:0]  s_branch_address,
    input  logic               s_taken,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_predicted_taken,
    output logic               m_prediction_correct,
    output logic               m_used_gshare,
    output logic [COUNT_W-1:0] m_correct_total
);

    localparam int DEPTH = 2 ** INDEX_BITS;

    tbp_state_t state_reg, state_next;

    logic [INDEX_BITS-1:0]   clr_reg;
    logic [HISTORY_BITS-1:0] hist_reg;
    logic [COUNT_W-1:0]      hits_reg, hits_next;
    logic [INDEX_BITS-1:0]   bi_reg;
    logic [INDEX_BITS-1:0]   gi_reg;
    logic                    taken_reg;

    logic                    m_valid_reg;
    logic                    m_pred_reg;
    logic                    m_hit_reg;
    logic                    m_gsh_reg;
    logic [COUNT_W-1:0]      m_total_reg;

    logic                    acc;
    logic                    upd_go;
    logic                    ram_we;
    logic [ADDR_W-1:0]       gx;
    logic [INDEX_BITS-1:0]   gi_in;
    logic [INDEX_BITS-1:0]   bc_waddr;
    logic [INDEX_BITS-1:0]   g_waddr;
    logic [2*CTR_W-1:0]      bc_wdata;
    logic [CTR_W-1:0]        g_wdata;
    logic [2*CTR_W-1:0]      bc_rdata;
    logic [CTR_W-1:0]        g_rdata;
    tbp_upd_t                upd;

    assign acc   = s_valid && s_ready;
    assign gx    = s_branch_address ^ ADDR_W'(hist_reg);
    assign gi_in = gx[INDEX_BITS-1:0];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == {INDEX_BITS{1'b1}}) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (acc) state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (upd_go) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        upd_go  = 1'b0;
        ram_we  = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we = 1'b1;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_UPDATE: begin
                upd_go = !m_valid_reg || m_ready;
                ram_we = upd_go;
            end
            default: ;
        endcase
    end

    always_comb begin
        if (state_reg == ST_CLEAR) begin
            bc_waddr = clr_reg;
            g_waddr  = clr_reg;
            bc_wdata = {CHO_STRONG_GSH, CTR_STRONG_T};
            g_wdata  = CTR_STRONG_T;
        end else begin
            bc_waddr = bi_reg;
            g_waddr  = gi_reg;
            bc_wdata = {upd.cho_next, upd.bim_next};
            g_wdata  = upd.gsh_next;
        end
    end

    tbp_ram #(.WIDTH(2 * CTR_W), .DEPTH(DEPTH)) u_bc_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (bc_waddr),
        .wdata (bc_wdata),
        .re    (acc),
        .raddr (s_branch_address[INDEX_BITS-1:0]),
        .rdata (bc_rdata)
    );

    tbp_ram #(.WIDTH(CTR_W), .DEPTH(DEPTH)) u_g_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .re    (acc),
        .raddr (gi_in),
        .rdata (g_rdata)
    );

    tbp_update u_update (
        .bim_ctr (bc_rdata[CTR_W-1:0]),
        .gsh_ctr (g_rdata),
        .cho_ctr (bc_rdata[2*CTR_W-1:CTR_W]),
        .taken   (taken_reg),
        .upd     (upd)
    );

    always_comb begin
        hits_next = hits_reg;
        if (upd.hit && hits_reg != {COUNT_W{1'b1}}) begin
            hits_next = hits_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            hist_reg    <= '0;
            hits_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + INDEX_BITS'(1);
            end
            if (upd_go) begin
                hist_reg    <= (hist_reg << 1) | HISTORY_BITS'(taken_reg);
                hits_reg    <= hits_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            bi_reg    <= s_branch_address[INDEX_BITS-1:0];
            gi_reg    <= gi_in;
            taken_reg <= s_taken;
        end
        if (upd_go) begin
            m_pred_reg  <= upd.pred;
            m_hit_reg   <= upd.hit;
            m_gsh_reg   <= upd.use_gshare;
            m_total_reg <= hits_next;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_predicted_taken    = m_pred_reg;
    assign m_prediction_correct = m_hit_reg;
    assign m_used_gshare        = m_gsh_reg;
    assign m_correct_total      = m_total_reg;

endmodule

// ===== sv/tbp_checker.sv =====
`timescale 1ns / 1ps

module tbp_checker import tbp_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_prediction_correct,
    input logic [COUNT_W-1:0] m_correct_total
);

    // sync reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // one request in flight at a time
    a_no_back_to_back: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while previous one in flight");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_correct_total)))
        else $error("stalled result changed");

    a_hit_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_prediction_correct) |-> (m_correct_total != '0))
        else $error("correct prediction not counted");

endmodule

bind tournament_branch_predictor tbp_checker u_tbp_checker (
    .aclk                 (aclk),
    .aresetn              (aresetn),
    .s_valid              (s_valid),
    .s_ready              (s_ready),
    .m_valid              (m_valid),
    .m_ready              (m_ready),
    .m_prediction_correct (m_prediction_correct),
    .m_correct_total      (m_correct_total)
);
